FILE: hw/rtl/cliq_pkg.sv
// Shared types and constants of the cliquet path payoff block.
// Holds number formats, register indexes, the queued word and the settings bundle.
// No dependencies.
package cliq_pkg;

   localparam int PRICE_W      = 32;  // unsigned Q16.16
   localparam int DISC_W       = 31;  // unsigned Q1.30
   localparam int MONEY_W      = 40;  // signed Q16.24
   localparam int SUM_W        = MONEY_W + 2;
   localparam int RATIO_FRAC   = 24;
   localparam int DISC_FRAC    = 30;
   localparam int DIV_STEPS    = MONEY_W - 1;
   localparam int DIV_PRE_SHIFT = DIV_STEPS - RATIO_FRAC;
   localparam int MUL_SPLIT    = MONEY_W / 2;
   localparam int PROD_W       = MUL_SPLIT + DISC_W;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 40;

   localparam logic signed [MONEY_W-1:0] MONEY_MAX    = 40'sh7F_FFFF_FFFF;
   localparam logic signed [MONEY_W-1:0] MONEY_MIN    = 40'sh80_0000_0000;
   localparam logic signed [MONEY_W-1:0] STRIKE_RESET = 40'sd16777216;

   localparam logic [CSR_INDEX_W-1:0] CSR_PUT_SELECT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIKE         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_CAP      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_FLOOR    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLOBAL_CAP     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLOBAL_FLOOR   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCRUED_COUPON = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRIOR_FIXING   = 3'd7;

   // What the back end has to do with a fixing.
   typedef enum logic [1:0] {
      OP_STORE,     // no previous price: nothing is added
      OP_SATURATE,  // ratio would not fit, or the previous price is zero
      OP_DIVIDE     // ratio is computed by the divider
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [PRICE_W-1:0]   price;
      logic [PRICE_W-1:0]   divisor;
      logic [DISC_W-1:0]    discount;
      logic                 first;
      logic                 last;
   } item_type;

   typedef struct packed {
      logic                        put_select;
      logic signed [MONEY_W-1:0]   strike;
      logic signed [MONEY_W-1:0]   local_cap;
      logic signed [MONEY_W-1:0]   local_floor;
      logic signed [MONEY_W-1:0]   global_cap;
      logic signed [MONEY_W-1:0]   global_floor;
      logic signed [MONEY_W-1:0]   accrued_coupon;
      logic [PRICE_W-1:0]          prior_fixing;
   } cfg_type;

endpackage

FILE: hw/rtl/cliq_front.sv
// Front end: accepts fixings, tracks the previous price and classifies each word.
// Depends on cliq_pkg.
module cliq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  cliq_pkg::cfg_type             cfg,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [cliq_pkg::PRICE_W-1:0]  req_fixing_price,
   input  logic [cliq_pkg::DISC_W-1:0]   req_discount,
   input  logic                          req_first_of_path,
   input  logic                          req_last_of_path,
   input  logic                          q_full,
   output logic                          q_push,
   output cliq_pkg::item_type            q_item
);
   import cliq_pkg::*;

   logic [PRICE_W-1:0] prev_ff, prev_in;
   logic               have_ff, have_in;
   logic [PRICE_W-1:0] prev_eff;
   logic               have_eff;
   logic [PRICE_W-1:0] price_top;

   assign req_full  = q_full;
   assign q_push    = req_push && !q_full;
   assign price_top = req_fixing_price >> DIV_PRE_SHIFT;

   always_comb begin
      // A path start replaces the stored price with the prior fixing.
      prev_eff = req_first_of_path ? cfg.prior_fixing : prev_ff;
      have_eff = req_first_of_path ? (cfg.prior_fixing != '0) : have_ff;

      q_item.price    = req_fixing_price;
      q_item.divisor  = prev_eff;
      q_item.discount = req_discount;
      q_item.first    = req_first_of_path;
      q_item.last     = req_last_of_path;
      // The quotient overflows the ratio range exactly when the upper price
      // bits reach the divisor; a zero divisor falls in the same case.
      priority if (!have_eff) begin
         q_item.op = OP_STORE;
      end else if (price_top >= prev_eff) begin
         q_item.op = OP_SATURATE;
      end else begin
         q_item.op = OP_DIVIDE;
      end

      prev_in = q_push ? req_fixing_price : prev_ff;
      have_in = q_push ? 1'b1 : have_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         have_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         have_ff <= have_in;
      end
   end

endmodule

FILE: hw/rtl/cliq_queue.sv
// Short first-in first-out queue of classified words between front and back end.
// Depends on cliq_pkg.
module cliq_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cliq_pkg::item_type  push_item,
   input  logic                pop,
   output cliq_pkg::item_type  pop_item,
   output logic                full,
   output logic                empty
);
   import cliq_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: hw/rtl/cliq_div.sv
// Radix-2 restoring divider for the performance ratio (price << 24) / previous.
// Depends on cliq_pkg. The caller guarantees the quotient fits in DIV_STEPS bits.
module cliq_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [cliq_pkg::PRICE_W-1:0]    price,
   input  logic [cliq_pkg::PRICE_W-1:0]    divisor,
   output logic                            done,
   output logic [cliq_pkg::DIV_STEPS-1:0]  quotient
);
   import cliq_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PRICE_W-1:0]   rem_ff, rem_in;
   logic [PRICE_W-1:0]   div_ff, div_in;
   logic [DIV_STEPS-1:0] sh_ff, sh_in;
   logic [DIV_STEPS-1:0] q_ff, q_in;
   logic [PRICE_W:0]     trial;
   logic [PRICE_W:0]     trial_diff;
   logic                 fits;

   assign done       = done_ff;
   assign quotient   = q_ff;
   assign trial      = {rem_ff, sh_ff[DIV_STEPS-1]};
   assign trial_diff = trial - {1'b0, div_ff};
   assign fits       = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      if (start) begin
         // The upper price bits are already below the divisor, so the
         // remaining DIV_STEPS dividend bits each yield one quotient bit.
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = price >> DIV_PRE_SHIFT;
         div_in  = divisor;
         sh_in   = {price[DIV_PRE_SHIFT-1:0], RATIO_FRAC'(0)};
         q_in    = '0;
      end else if (busy_ff) begin
         rem_in = fits ? trial_diff[PRICE_W-1:0] : trial[PRICE_W-1:0];
         sh_in  = sh_ff << 1;
         q_in   = {q_ff[DIV_STEPS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

FILE: hw/rtl/cliq_back.sv
// Back end: ratio, payoff, clamp, discount, accumulate and the result register.
// Depends on cliq_pkg and cliq_div.
module cliq_back (
   input  logic                                clock,
   input  logic                                reset,
   input  cliq_pkg::cfg_type                   cfg,
   input  logic                                q_empty,
   input  cliq_pkg::item_type                  q_item,
   output logic                                q_pop,
   input  logic                                rsp_pop,
   output logic                                rsp_empty,
   output logic signed [cliq_pkg::MONEY_W-1:0] rsp_path_value,
   output logic                                rsp_saturated
);
   import cliq_pkg::*;

   localparam int WIDE_W = PROD_W + MUL_SPLIT;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIVIDE,
      S_PAYOFF,
      S_MAGNITUDE,
      S_MUL_LO,
      S_MUL_HI,
      S_SCALE,
      S_ACCUM,
      S_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   item_type                   item_ff, item_in;
   logic [MONEY_W-1:0]         ratio_ff, ratio_in;
   logic signed [MONEY_W-1:0]  pay_ff, pay_in;
   logic                       neg_ff, neg_in;
   logic [MONEY_W-1:0]         mag_ff, mag_in;
   logic [PROD_W-1:0]          pp_ff, pp_in;
   logic [PROD_W-1:0]          lo_ff, lo_in;
   logic [MONEY_W-1:0]         scaled_ff, scaled_in;
   logic signed [MONEY_W-1:0]  sum_ff, sum_in;
   logic                       sticky_ff, sticky_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [MONEY_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic                       div_start;
   logic                       div_done;
   logic [DIV_STEPS-1:0]       div_quotient;

   logic signed [MONEY_W:0]    ratio_x, strike_x, floor_x, cap_x;
   logic signed [MONEY_W:0]    diff, pay_pos, pay_lo, pay_hi;
   logic [WIDE_W-1:0]          wide;
   logic [SUM_W-1:0]           term, sum_wide;
   logic                       over, under;
   logic signed [MONEY_W-1:0]  glob_lo, glob_out;

   cliq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .price    (q_item.price),
      .divisor  (q_item.divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_path_value = rsp_value_ff;
   assign rsp_saturated  = rsp_sat_ff;

   // Period payoff: vanilla call or put on the ratio, then the local clamp.
   always_comb begin
      ratio_x  = $signed({ratio_ff[MONEY_W-1], ratio_ff});
      strike_x = $signed({cfg.strike[MONEY_W-1], cfg.strike});
      floor_x  = $signed({cfg.local_floor[MONEY_W-1], cfg.local_floor});
      cap_x    = $signed({cfg.local_cap[MONEY_W-1], cfg.local_cap});
      diff     = cfg.put_select ? (strike_x - ratio_x) : (ratio_x - strike_x);
      pay_pos  = diff[MONEY_W] ? '0 : diff;
      pay_lo   = (pay_pos < floor_x) ? floor_x : pay_pos;
      pay_hi   = (pay_lo > cap_x) ? cap_x : pay_lo;
   end

   // Discounted term and the saturating sum.
   always_comb begin
      wide     = {pp_ff, MUL_SPLIT'(0)} + WIDE_W'(lo_ff);
      term     = SUM_W'(scaled_ff);
      sum_wide = {{(SUM_W - MONEY_W){sum_ff[MONEY_W-1]}}, sum_ff}
                 + (neg_ff ? ~term : term) + SUM_W'(neg_ff);
      over     = !sum_wide[SUM_W-1] && (sum_wide[SUM_W-2:MONEY_W-1] != '0);
      under    = sum_wide[SUM_W-1] && (sum_wide[SUM_W-2:MONEY_W-1] != '1);
      glob_lo  = (sum_ff < cfg.global_floor) ? cfg.global_floor : sum_ff;
      glob_out = (glob_lo > cfg.global_cap) ? cfg.global_cap : glob_lo;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      ratio_in     = ratio_ff;
      pay_in       = pay_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      pp_in        = pp_ff;
      lo_in        = lo_ff;
      scaled_in    = scaled_ff;
      sum_in       = sum_ff;
      sticky_in    = sticky_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;

      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (q_item.first) begin
                  sum_in    = cfg.accrued_coupon;
                  sticky_in = 1'b0;
               end
               unique case (q_item.op)
                  OP_STORE: begin
                     state_in = S_FINISH;
                  end
                  OP_SATURATE: begin
                     ratio_in  = MONEY_MAX;
                     sticky_in = 1'b1;
                     state_in  = S_PAYOFF;
                  end
                  OP_DIVIDE: begin
                     div_start = 1'b1;
                     state_in  = S_DIVIDE;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_DIVIDE: begin
            if (div_done) begin
               ratio_in = MONEY_W'(div_quotient);
               state_in = S_PAYOFF;
            end
         end
         S_PAYOFF: begin
            pay_in   = pay_hi[MONEY_W-1:0];
            state_in = S_MAGNITUDE;
         end
         S_MAGNITUDE: begin
            neg_in   = pay_ff[MONEY_W-1];
            mag_in   = pay_ff[MONEY_W-1] ? (~pay_ff + 1'b1) : pay_ff;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            pp_in    = PROD_W'(mag_ff[MUL_SPLIT-1:0]) * PROD_W'(item_ff.discount);
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            lo_in    = pp_ff;
            pp_in    = PROD_W'(mag_ff[MONEY_W-1:MUL_SPLIT]) * PROD_W'(item_ff.discount);
            state_in = S_SCALE;
         end
         S_SCALE: begin
            scaled_in = wide[DISC_FRAC+MONEY_W-1:DISC_FRAC];
            state_in  = S_ACCUM;
         end
         S_ACCUM: begin
            priority if (over) begin
               sum_in    = MONEY_MAX;
               sticky_in = 1'b1;
            end else if (under) begin
               sum_in    = MONEY_MIN;
               sticky_in = 1'b1;
            end else begin
               sum_in = sum_wide[MONEY_W-1:0];
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!item_ff.last) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = glob_out;
               rsp_sat_in   = sticky_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      ratio_ff     <= ratio_in;
      pay_ff       <= pay_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      pp_ff        <= pp_in;
      lo_ff        <= lo_in;
      scaled_ff    <= scaled_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/cliquet_path_payoff.sv
// Top level of the cliquet path payoff block: settings registers, front end,
// word queue and back end. Depends on cliq_pkg, cliq_front, cliq_queue, cliq_back.
//
//   Channel   Direction  Handshake          Word
//   req_      in         push / full        fixing_price, discount, first/last flags
//   rsp_      out        empty / pop        path_value, saturated
//   csr_      in         valid / ready      csr_index, csr_data
//
// A fixing that needs the ratio divider passes in the back end through fetch,
// the 39-step radix-2 divider, payoff with clamp, magnitude, the two halves of
// the discount multiply, scaling, accumulation and finish. A fixing whose ratio
// saturates skips the divider; one that is only stored goes straight to finish.
// The front end keeps taking words until the queue is full, and a result waits
// in its own register, so the request side may stall without blocking the back end.
// Reset is synchronous; it restores every setting to its default and clears the
// previous price, the running sum and the saturation flag.
module cliquet_path_payoff #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic [cliq_pkg::PRICE_W-1:0]          req_fixing_price,
   input  logic [cliq_pkg::DISC_W-1:0]           req_discount,
   input  logic                                  req_first_of_path,
   input  logic                                  req_last_of_path,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [cliq_pkg::MONEY_W-1:0]   rsp_path_value,
   output logic                                  rsp_saturated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cliq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cliq_pkg::CSR_DATA_W-1:0]       csr_data
);
   import cliq_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      q_push, q_pop, q_full, q_empty;
   item_type  push_item, pop_item;

   // Settings are always writable; the user must change them only while the block is idle; the block does not check.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PUT_SELECT:     cfg_in.put_select     = csr_data[0];
            CSR_STRIKE:         cfg_in.strike         = $signed(csr_data[MONEY_W-1:0]);
            CSR_LOCAL_CAP:      cfg_in.local_cap      = $signed(csr_data[MONEY_W-1:0]);
            CSR_LOCAL_FLOOR:    cfg_in.local_floor    = $signed(csr_data[MONEY_W-1:0]);
            CSR_GLOBAL_CAP:     cfg_in.global_cap     = $signed(csr_data[MONEY_W-1:0]);
            CSR_GLOBAL_FLOOR:   cfg_in.global_floor   = $signed(csr_data[MONEY_W-1:0]);
            CSR_ACCRUED_COUPON: cfg_in.accrued_coupon = $signed(csr_data[MONEY_W-1:0]);
            CSR_PRIOR_FIXING:   cfg_in.prior_fixing   = csr_data[PRICE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.put_select     <= 1'b0;
         cfg_ff.strike         <= STRIKE_RESET;
         cfg_ff.local_cap      <= MONEY_MAX;
         cfg_ff.local_floor    <= '0;
         cfg_ff.global_cap     <= MONEY_MAX;
         cfg_ff.global_floor   <= MONEY_MIN;
         cfg_ff.accrued_coupon <= '0;
         cfg_ff.prior_fixing   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end tracks the previous price and decides per word whether the
   // divider is needed, so the back end never looks back at earlier words.
   cliq_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_fixing_price  (req_fixing_price),
      .req_discount      (req_discount),
      .req_first_of_path (req_first_of_path),
      .req_last_of_path  (req_last_of_path),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_item            (push_item)
   );

   cliq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The back end owns the running sum, the saturation flag and the result register.
   cliq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_empty        (q_empty),
      .q_item         (pop_item),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_path_value (rsp_path_value),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

FILE: hw/rtl/cliq_checker.sv
// Port-level checks for the cliquet path payoff block, bound to its top level.
// Depends on cliq_pkg and cliquet_path_payoff.
module cliq_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_full,
   input logic                                  rsp_empty,
   input logic                                  rsp_pop,
   input logic signed [cliq_pkg::MONEY_W-1:0]   rsp_path_value,
   input logic                                  rsp_saturated
);

   // A waiting result holds still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_path_value)
                                 && $stable(rsp_saturated))
      else $error("result changed while waiting");

   // Reset leaves the queue open and no result pending.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !req_full && rsp_empty)
      else $error("queue or result register not cleared by reset");

   // A result cannot follow reset straight away: it must pass the queue and the back end first.
   a_no_early_rsp: assert property (@(posedge clock)
      $past(reset) |=> rsp_empty)
      else $error("result appeared too soon after reset");

   // A taken result leaves the register empty before the next one: the back end refills the
   // result register only when it was empty.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop |=> rsp_empty)
      else $error("result register refilled on the cycle it was taken");

endmodule

bind cliquet_path_payoff cliq_checker u_checker (.*);
